// ===== hdl/svh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svh_pkg
// Shared constants and types of the sorted value histogram unit.
// ----------------------------------------------------------------------------
package svh_pkg;

  localparam int MAX_DISTINCT = 32;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 16;
  localparam int USED_W       = $clog2(MAX_DISTINCT + 1);
  localparam int OUT_DATA_W   = VAL_W + CNT_W;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic absorb;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic last_entry;
  } status_t;

endpackage

// ===== hdl/svh_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svh_datapath
// Sorted register table with parallel compare, shift-insert and shift-out.
// ----------------------------------------------------------------------------
module svh_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  svh_pkg::cmd_t                     cmd,
  input  logic signed [svh_pkg::VAL_W-1:0]  sample,
  output svh_pkg::status_t                  status,
  output logic signed [svh_pkg::VAL_W-1:0]  head_value,
  output logic [svh_pkg::CNT_W-1:0]         head_count,
  output logic                              overflow
);

  localparam int N = svh_pkg::MAX_DISTINCT;

  logic signed [svh_pkg::VAL_W-1:0] val_r [N];
  logic [svh_pkg::CNT_W-1:0]        cnt_r [N];
  logic [svh_pkg::USED_W-1:0]       used_r, used_nxt;
  logic                             ovf_r, ovf_nxt;

  logic [N-1:0] valid, lt, eq;
  logic         found, full;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid[i] = svh_pkg::USED_W'(i) < used_r;
      lt[i]    = valid[i] && (val_r[i] < sample);
      eq[i]    = valid[i] && (val_r[i] == sample);
    end
  end

  assign found = |eq;
  assign full  = used_r == svh_pkg::USED_W'(N);

  for (genvar i = 0; i < N; i++) begin : g_entry
    logic first_ge;
    if (i == 0) begin : g_first
      assign first_ge = 1'b1;
    end else begin : g_rest
      assign first_ge = lt[i-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.absorb) begin
        if (found) begin
          if (eq[i] && cnt_r[i] != '1) begin
            cnt_r[i] <= cnt_r[i] + svh_pkg::CNT_W'(1);
          end
        end else if (!full && !lt[i]) begin
          if (first_ge) begin
            val_r[i] <= sample;
            cnt_r[i] <= svh_pkg::CNT_W'(1);
          end else begin
            if (i > 0) begin
              val_r[i] <= val_r[(i > 0) ? i - 1 : 0];
              cnt_r[i] <= cnt_r[(i > 0) ? i - 1 : 0];
            end
          end
        end
      end else if (cmd.drain) begin
        if (i < N - 1) begin
          val_r[i] <= val_r[(i < N - 1) ? i + 1 : i];
          cnt_r[i] <= cnt_r[(i < N - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    if (cmd.absorb && !found) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        used_nxt = used_r + svh_pkg::USED_W'(1);
      end
    end else if (cmd.drain) begin
      used_nxt = used_r - svh_pkg::USED_W'(1);
      if (status.last_entry) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign status.last_entry = used_r == svh_pkg::USED_W'(1);
  assign head_value        = val_r[0];
  assign head_count        = cnt_r[0];
  assign overflow          = ovf_r;

endmodule

// ===== hdl/svh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svh_ctrl
// Collect/drain sequencer of the sorted value histogram unit.
// ----------------------------------------------------------------------------
module svh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  svh_pkg::status_t  status,
  output svh_pkg::cmd_t     cmd
);

  svh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svh_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      svh_pkg::ST_COLLECT: begin
        in_tready  = 1'b1;
        cmd.absorb = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = svh_pkg::ST_DRAIN;
        end
      end
      svh_pkg::ST_DRAIN: begin
        out_tvalid = 1'b1;
        cmd.drain  = out_tready;
        if (out_tready && status.last_entry) begin
          state_nxt = svh_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_nxt = svh_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

// ===== hdl/sorted_value_histogram_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_value_histogram_unit
// Frequency table of distinct signed values, emitted in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the in_ stream, one signed 32-bit value per transfer;
//   in_tlast marks the last sample of a vector. Each sample is compared
//   against all table entries in parallel and counted or shift-inserted, so
//   one sample is taken every cycle while collecting.
//   After the transfer with in_tlast, in_tready drops and the table drains
//   on the out_ stream, one transfer per distinct value, smallest first,
//   starting the next cycle. out_tlast marks the last entry, out_tuser is
//   the sticky overflow flag of the run (a new value arrived with all 32
//   entries in use and was dropped). Counts saturate at 65535.
//   A vector of N distinct values drains as N out_ transfers after its last
//   sample; sampling resumes the cycle after the last out_ transfer.
//   A stalled receiver simply holds the current entry; nothing is lost.
//   Reset (rst_n low, synchronous) empties the table and clears overflow.
// ----------------------------------------------------------------------------
module sorted_value_histogram_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] sample_value
  input  logic                              in_tlast,   // final_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [svh_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] distinct_value,
                                                        // [47:32] occurrences
  output logic                              out_tlast,  // run_end
  output logic                              out_tuser   // table_overflow
);

  svh_pkg::cmd_t                    cmd;
  svh_pkg::status_t                 status;
  logic signed [svh_pkg::VAL_W-1:0] head_value;
  logic [svh_pkg::CNT_W-1:0]        head_count;
  logic                             overflow;

  svh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  svh_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample     ($signed(in_tdata)),
    .status     (status),
    .head_value (head_value),
    .head_count (head_count),
    .overflow   (overflow)
  );

  assign out_tdata = {head_count, head_value};
  assign out_tlast = status.last_entry;
  assign out_tuser = overflow;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks sorted_value_histogram_unit against a software frequency table.
// Sample vectors go in on the in_ stream. Every transfer is also counted into
// a local sorted table, and the table is flushed into the expected bins on
// the vector's last sample. Each out_ transfer is checked against the oldest
// expected bin. The directed vectors cover the value extremes and a dropped
// entry on a full table. Random vectors follow. Both sides idle at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 150;

  typedef struct {
    logic [svh_pkg::VAL_W-1:0] value;
    logic                      fin;
  } sample_t;

  typedef struct {
    logic [svh_pkg::VAL_W-1:0] value;
    logic [svh_pkg::CNT_W-1:0] count;
    logic                      run_end;
    logic                      dropped;
  } bin_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata   = '0;
  logic                           in_tlast   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [svh_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;

  sorted_value_histogram_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // local frequency table
  logic signed [svh_pkg::VAL_W-1:0] hist_val [svh_pkg::MAX_DISTINCT];
  logic [svh_pkg::CNT_W-1:0]        hist_cnt [svh_pkg::MAX_DISTINCT];
  int                               hist_used    = 0;
  bit                               hist_dropped = 1'b0;

  sample_t sample_q[$];
  bin_t    expected_bins[$];

  int   samples_taken   = 0;
  int   total_samples   = 0;
  int   directed_total  = 0;
  int   stall_cycles    = 0;
  int   errors          = 0;
  int   results_checked = 0;
  int   runs_done       = 0;
  int   overflow_runs   = 0;
  int   send_gap        = 0;
  int   recv_wait       = 0;
  int   hold_left       = 0;
  bit   hold_done       = 1'b0;
  logic in_xfer         = 1'b0;
  logic out_xfer        = 1'b0;
  logic out_xfer_mid    = 1'b0;
  logic steady;

  // stretches with no idling on either side
  assign steady = ((samples_taken / 40) % 3) == 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void count_sample(input logic [svh_pkg::VAL_W-1:0] raw,
                                       input logic fin);
    logic signed [svh_pkg::VAL_W-1:0] v;
    int   pos;
    bin_t b;
    v   = raw;
    pos = 0;
    while (pos < hist_used && hist_val[pos] < v) pos++;
    if (pos < hist_used && hist_val[pos] == v) begin
      if (hist_cnt[pos] != '1) hist_cnt[pos] = hist_cnt[pos] + 1'b1;
    end else if (hist_used == svh_pkg::MAX_DISTINCT) begin
      hist_dropped = 1'b1;
    end else begin
      for (int k = hist_used; k > pos; k--) begin
        hist_val[k] = hist_val[k-1];
        hist_cnt[k] = hist_cnt[k-1];
      end
      hist_val[pos] = v;
      hist_cnt[pos] = svh_pkg::CNT_W'(1);
      hist_used++;
    end
    if (fin) begin
      for (int k = 0; k < hist_used; k++) begin
        b.value   = hist_val[k];
        b.count   = hist_cnt[k];
        b.run_end = (k == hist_used - 1);
        b.dropped = hist_dropped;
        expected_bins.insert(expected_bins.size(), b);
      end
      runs_done++;
      if (hist_dropped) overflow_runs++;
      hist_used    = 0;
      hist_dropped = 1'b0;
    end
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  task automatic check_bin();
    bin_t want;
    if (expected_bins.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual value 0x%0h count %0d",
               $time, out_tdata[svh_pkg::VAL_W-1:0],
               out_tdata[svh_pkg::VAL_W +: svh_pkg::CNT_W]);
    end else begin
      want = expected_bins.pop_front();
      results_checked++;
      if (out_tdata[svh_pkg::VAL_W-1:0] !== want.value)
        note_mismatch("distinct_value", want.value, out_tdata[svh_pkg::VAL_W-1:0]);
      if (out_tdata[svh_pkg::VAL_W +: svh_pkg::CNT_W] !== want.count)
        note_mismatch("occurrences", 32'(want.count),
                      32'(out_tdata[svh_pkg::VAL_W +: svh_pkg::CNT_W]));
      if (out_tlast !== want.run_end)
        note_mismatch("run_end", 32'(want.run_end), 32'(out_tlast));
      if (out_tuser !== want.dropped)
        note_mismatch("table_overflow", 32'(want.dropped), 32'(out_tuser));
    end
  endtask

  // transfer accounting and checking
  always @(posedge clk) begin
    in_xfer      <= rst_n && in_tvalid && in_tready;
    out_xfer     <= rst_n && out_tvalid && out_tready;
    out_xfer_mid <= rst_n && out_tvalid && out_tready && !out_tlast;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (in_tvalid && in_tready) begin
        count_sample(in_tdata, in_tlast);
        samples_taken <= samples_taken + 1;
      end
      if (out_tvalid && out_tready) check_bin();
    end
  end

  // sample driver
  always @(negedge clk) begin : drive_samples
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (sample_q.size() > 0) begin
        s = sample_q.pop_front();
        in_tdata  <= s.value;
        in_tlast  <= s.fin;
        in_tvalid <= 1'b1;
        send_gap  <= steady ? 0 : $urandom_range(0, 3);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin : drive_ready
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && out_xfer_mid && samples_taken > directed_total &&
                 sample_q.size() > 0) begin
      // long hold-off mid-drain while samples keep coming
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (out_xfer) begin
      w = steady ? 0 : $urandom_range(0, 3);
      recv_wait  <= w;
      out_tready <= (w == 0);
    end else if (recv_wait > 0) begin
      recv_wait  <= recv_wait - 1;
      out_tready <= (recv_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_sample(input logic [svh_pkg::VAL_W-1:0] v, input logic fin);
    sample_t s;
    s.value = v;
    s.fin   = fin;
    sample_q.insert(sample_q.size(), s);
  endtask

  function automatic logic [svh_pkg::VAL_W-1:0] draw_value(input int pool);
    logic [svh_pkg::VAL_W-1:0] v;
    case (pool)
      0:       v = $urandom();
      1:       v = 32'($urandom_range(0, 15)) - 32'd8;
      2:       v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff8) +
                   32'($urandom_range(0, 7));
      default: v = draw_value($urandom_range(0, 2));
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int run_len;
    int pool;
    int random_count;

    // extremes, single-entry vector, duplicate on the last sample
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h7fff_ffff, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hffff_ffff, 1'b0);
    push_sample(32'h0000_0001, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hffff_ffff, 1'b0);
    push_sample(32'h7fff_ffff, 1'b1);
    push_sample(32'd5, 1'b0);
    push_sample(32'd5, 1'b0);
    push_sample(32'd5, 1'b1);
    // full table: descending inserts, dropped values, hits after full
    for (int i = 0; i < 34; i++) push_sample(32'((33 - i) * 1000 - 17000), 1'b0);
    push_sample(32'd16000, 1'b0);
    push_sample(-32'sd15000, 1'b0);
    push_sample(-32'sd17000, 1'b1);
    // overflow flag must be clear on the next vector
    push_sample(32'd7, 1'b1);
    directed_total = sample_q.size();

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       run_len = $urandom_range(33, 45);
        1, 2:    run_len = 1;
        default: run_len = $urandom_range(2, 12);
      endcase
      pool = (run_len > 32) ? 0 : $urandom_range(0, 3);
      for (int i = 0; i < run_len; i++) push_sample(draw_value(pool), i == run_len - 1);
      random_count += run_len;
    end
    total_samples = sample_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (samples_taken < total_samples || expected_bins.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d samples in %0d vectors, %0d results checked.",
             samples_taken, runs_done, results_checked);
    $display("%0d vectors overflowed the table, %0d errors.",
             overflow_runs, errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
